@@ rtl/core/bic_pkg.sv @@
// shared types, bus map constants and reset tables for the banked interrupt controller
// no dependencies; used by banked_interrupt_controller_core
package bic_pkg;

    localparam int DATA_W      = 32;
    localparam int IRQ_W       = 5;
    localparam int MAX_BANKS   = 5;
    localparam int BUS_BASE    = 8'h40;
    localparam int BANK_STRIDE = 24;
    localparam int MSG_BANK    = 3;
    localparam int NUM_DEC     = 8;   // bank codes reachable from an 8-bit offset

    typedef enum logic [1:0] {
        CMD_LINE  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        OFF_STATUS = 5'd0,
        OFF_ENABLE = 5'd4,
        OFF_SET    = 5'd8,
        OFF_CLEAR  = 5'd12,
        OFF_POL    = 5'd16,
        OFF_EDGE   = 5'd20
    } reg_off_t;

    typedef struct packed {
        logic [2:0] bank;
        logic [4:0] off;
    } bus_dec_t;

    // split an offset above the bus base into bank and register offset
    function automatic bus_dec_t bus_decode(input logic [7:0] rel);
        bus_dec_t d;
        d.bank = 3'd0;
        d.off  = rel[4:0];
        for (int k = 1; k < NUM_DEC; k++) begin
            if (rel >= 8'(BANK_STRIDE * k)) begin
                d.bank = 3'(k);
                d.off  = 5'(rel - 8'(BANK_STRIDE * k));
            end
        end
        return d;
    endfunction

    function automatic logic [DATA_W-1:0] pol_reset(input int bank);
        logic [DATA_W-1:0] v;
        v = 32'hffffffff;
        if (bank == 0)
            v = 32'hff7fffff;
        else if (bank == 1)
            v = 32'hfeffffff;
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] edge_reset(input int bank);
        return (bank == 3 || bank == 4) ? 32'hffffffff : 32'h0;
    endfunction

    function automatic logic [DATA_W-1:0] clear_reset(input int bank);
        return (bank == 4) ? 32'hffffffff : 32'h0;
    endfunction

endpackage

@@ rtl/core/banked_interrupt_controller_core.sv @@
// banked interrupt controller: line events, bus register file and per-bank irq summary
// depends on bic_pkg
//
// pipeline: a transaction passes the input register and then the result register
// throughput: one transaction per cycle; in_ready drops only while both registers are full
// and out_ready is low
// reset: asynchronous, active low; clears valid flags and loads the bank register reset values
module banked_interrupt_controller_core #(
    parameter int NUM_BANKS = bic_pkg::MAX_BANKS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 cmd,
    input  logic [7:0]                 line_number,
    input  logic                       line_level,
    input  logic [7:0]                 address,
    input  logic [bic_pkg::DATA_W-1:0] write_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [bic_pkg::DATA_W-1:0] read_data,
    output logic [bic_pkg::IRQ_W-1:0]  irq_out
);

    // input register
    logic                       s1_valid_reg;
    bic_pkg::cmd_t              cmd_reg;
    logic [7:0]                 line_number_reg;
    logic                       line_level_reg;
    logic [7:0]                 address_reg;
    logic [bic_pkg::DATA_W-1:0] write_data_reg;

    // bank state
    logic [bic_pkg::DATA_W-1:0] status_reg  [NUM_BANKS];
    logic [bic_pkg::DATA_W-1:0] enable_reg  [NUM_BANKS];
    logic [bic_pkg::DATA_W-1:0] set_reg     [NUM_BANKS];
    logic [bic_pkg::DATA_W-1:0] clear_reg   [NUM_BANKS];
    logic [bic_pkg::DATA_W-1:0] pol_reg     [NUM_BANKS];
    logic [bic_pkg::DATA_W-1:0] edge_reg    [NUM_BANKS];
    logic [bic_pkg::DATA_W-1:0] last_reg    [NUM_BANKS];

    logic [bic_pkg::DATA_W-1:0] status_next [NUM_BANKS];
    logic [bic_pkg::DATA_W-1:0] enable_next [NUM_BANKS];
    logic [bic_pkg::DATA_W-1:0] set_next    [NUM_BANKS];
    logic [bic_pkg::DATA_W-1:0] clear_next  [NUM_BANKS];
    logic [bic_pkg::DATA_W-1:0] pol_next    [NUM_BANKS];
    logic [bic_pkg::DATA_W-1:0] edge_next   [NUM_BANKS];
    logic [bic_pkg::DATA_W-1:0] last_next   [NUM_BANKS];

    // result register
    logic                       out_valid_reg;
    logic [bic_pkg::DATA_W-1:0] read_data_reg;
    logic [bic_pkg::IRQ_W-1:0]  irq_out_reg;
    logic [bic_pkg::DATA_W-1:0] read_data_next;
    logic [bic_pkg::IRQ_W-1:0]  irq_out_next;

    logic                       advance;
    bic_pkg::bus_dec_t          dec;
    logic                       below_base;
    logic                       msg_port;
    logic [2:0]                 wr_bank;
    logic [4:0]                 wr_off;
    logic [bic_pkg::DATA_W-1:0] wr_data;
    logic [bic_pkg::DATA_W-1:0] line_mask;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign irq_out   = irq_out_reg;

    assign below_base = (address_reg < 8'(bic_pkg::BUS_BASE));
    assign dec        = bic_pkg::bus_decode(address_reg - 8'(bic_pkg::BUS_BASE));
    assign msg_port   = (address_reg == 8'd0);
    assign wr_bank    = msg_port ? 3'(bic_pkg::MSG_BANK) : dec.bank;
    assign wr_off     = msg_port ? bic_pkg::OFF_SET : dec.off;
    assign wr_data    = msg_port ? (32'd1 << write_data_reg[4:0]) : write_data_reg;
    assign line_mask  = 32'd1 << line_number_reg[4:0];

    always_comb
    begin
        logic ev_hit;
        logic wr_hit;
        logic on;
        read_data_next = '0;
        irq_out_next   = '0;
        if (cmd_reg == bic_pkg::CMD_READ && below_base)
            read_data_next = '1;
        for (int i = 0; i < NUM_BANKS; i++)
        begin
            status_next[i] = status_reg[i];
            enable_next[i] = enable_reg[i];
            set_next[i]    = set_reg[i];
            clear_next[i]  = clear_reg[i];
            pol_next[i]    = pol_reg[i];
            edge_next[i]   = edge_reg[i];
            last_next[i]   = last_reg[i];

            ev_hit = (cmd_reg == bic_pkg::CMD_LINE) && (line_number_reg[7:5] == 3'(i));
            wr_hit = (cmd_reg == bic_pkg::CMD_WRITE) && (msg_port || !below_base)
                     && (wr_bank == 3'(i));
            on = pol_reg[i][line_number_reg[4:0]] ? line_level_reg : !line_level_reg;

            if (ev_hit)
            begin
                // last level follows the polarity-adjusted line in both modes
                if (on)
                    last_next[i] = last_reg[i] | line_mask;
                else
                    last_next[i] = last_reg[i] & ~line_mask;
                if (edge_reg[i][line_number_reg[4:0]])
                begin
                    if (on && !last_reg[i][line_number_reg[4:0]])
                        status_next[i] = status_reg[i] | line_mask;
                end
                else if (on)
                begin
                    status_next[i] = status_reg[i] | line_mask;
                end
                else
                begin
                    status_next[i] = status_reg[i] & ~line_mask;
                end
            end

            if (wr_hit)
            begin
                unique case (wr_off)
                    bic_pkg::OFF_ENABLE: enable_next[i] = wr_data;
                    bic_pkg::OFF_SET:
                    begin
                        set_next[i]    = wr_data;
                        enable_next[i] = enable_reg[i] | wr_data;
                    end
                    bic_pkg::OFF_CLEAR:
                    begin
                        clear_next[i]  = wr_data;
                        enable_next[i] = enable_reg[i] & ~wr_data;
                        status_next[i] = status_reg[i] & ~wr_data;
                        last_next[i]   = last_reg[i] & ~wr_data;
                    end
                    bic_pkg::OFF_POL:    pol_next[i]  = wr_data;
                    bic_pkg::OFF_EDGE:   edge_next[i] = wr_data;
                    default:             ;
                endcase
            end

            if (cmd_reg == bic_pkg::CMD_READ && !below_base && dec.bank == 3'(i))
            begin
                unique case (dec.off)
                    bic_pkg::OFF_STATUS: read_data_next = status_reg[i];
                    bic_pkg::OFF_ENABLE: read_data_next = enable_reg[i];
                    bic_pkg::OFF_SET:    read_data_next = set_reg[i];
                    bic_pkg::OFF_CLEAR:  read_data_next = clear_reg[i];
                    bic_pkg::OFF_POL:    read_data_next = pol_reg[i];
                    bic_pkg::OFF_EDGE:   read_data_next = edge_reg[i];
                    default:             read_data_next = '0;
                endcase
            end

            if (i < bic_pkg::IRQ_W)
                irq_out_next[i] = |(status_next[i] & enable_next[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_BANKS; i++)
            begin
                status_reg[i] <= '0;
                enable_reg[i] <= '0;
                set_reg[i]    <= '0;
                last_reg[i]   <= '0;
                clear_reg[i]  <= bic_pkg::clear_reset(i);
                pol_reg[i]    <= bic_pkg::pol_reset(i);
                edge_reg[i]   <= bic_pkg::edge_reset(i);
            end
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                for (int i = 0; i < NUM_BANKS; i++)
                begin
                    status_reg[i] <= status_next[i];
                    enable_reg[i] <= enable_next[i];
                    set_reg[i]    <= set_next[i];
                    clear_reg[i]  <= clear_next[i];
                    pol_reg[i]    <= pol_next[i];
                    edge_reg[i]   <= edge_next[i];
                    last_reg[i]   <= last_next[i];
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg         <= bic_pkg::cmd_t'(cmd);
            line_number_reg <= line_number;
            line_level_reg  <= line_level;
            address_reg     <= address;
            write_data_reg  <= write_data;
        end
        if (advance)
        begin
            read_data_reg <= read_data_next;
            irq_out_reg   <= irq_out_next;
        end
    end

endmodule
